// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Command and status codes, and default sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH   = 1024;
   localparam int DEQ_DATA_W  = 32;
   localparam int DEQ_OCC_W   = 11;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ_FRONT = 3'd4,
      CMD_READ_BACK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Deque RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue core
// Circular buffer in RAM addressed by a head pointer and a word count.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is registered in the result stage and then in
// the output register, which holds its response while rsp_stall is high.
// Throughput: one request per cycle unless a stalled output backs up; the RAM
// takes at most one write or one registered read per request; pointer and count
// update as the request is accepted. Reset: clears head pointer, word count and
// pipeline valids; RAM contents are left as they are and never read unwritten.
// ----------------------------------------------------------------------------
module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic [DEQ_DATA_W-1:0] req_push_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DEQ_DATA_W-1:0] rsp_read_value,
   output logic [1:0]            rsp_status,
   output logic [DEQ_OCC_W-1:0]  rsp_occupancy,
   output logic                  rsp_is_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             s1_v_ff, s1_v_in;
   logic             s1_use_ram_ff, s1_use_ram_in;
   status_type       s1_status_ff, s1_status_in;
   logic [CNT_W-1:0] s1_count_ff;

   logic                  out_v_ff, out_v_in;
   logic [DEQ_DATA_W-1:0] out_value_ff;
   status_type            out_status_ff;
   logic [CNT_W-1:0]      out_count_ff;

   logic                  accept;
   logic                  s1_move;
   logic                  is_full, is_empty_now;
   logic [SUM_W-1:0]      tail_sum, back_sum;
   logic [PTR_W-1:0]      tail_idx, back_idx, head_inc, head_dec;
   logic                  wr_en, rd_en;
   logic [PTR_W-1:0]      wr_addr, rd_addr;
   logic [DEQ_DATA_W-1:0] rd_data;
   logic [CNT_W+DEQ_OCC_W-1:0] occ_ext;

   // Advance the result stage when the output register is free or draining.
   assign s1_move   = s1_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = s1_v_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign is_full      = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      back_sum = tail_sum - SUM_W'(1);
      tail_idx = PTR_W'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
      back_idx = PTR_W'((back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum);
      head_inc = (head_ff == LAST_P) ? '0 : head_ff + PTR_W'(1);
      head_dec = (head_ff == '0) ? LAST_P : head_ff - PTR_W'(1);
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_idx;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      s1_use_ram_in = 1'b0;
      s1_status_in  = ST_OK;
      if (accept) begin
         unique case (cmd_type'(req_command))
            CMD_PUSH_FRONT: begin
               if (is_full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (is_full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_idx;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_FRONT, CMD_READ_FRONT: begin
               if (is_empty_now) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en         = 1'b1;
                  rd_addr       = head_ff;
                  s1_use_ram_in = 1'b1;
                  if (cmd_type'(req_command) == CMD_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            CMD_POP_BACK, CMD_READ_BACK: begin
               if (is_empty_now) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en         = 1'b1;
                  rd_addr       = back_idx;
                  s1_use_ram_in = 1'b1;
                  if (cmd_type'(req_command) == CMD_POP_BACK) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               // unused codes: leave state alone, report ok
            end
         endcase
      end
   end

   assign s1_v_in  = accept || (s1_v_ff && !s1_move);
   assign out_v_in = s1_move || (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_ram_ff <= s1_use_ram_in;
         s1_status_ff  <= s1_status_in;
         s1_count_ff   <= count_in;
      end
      if (s1_move) begin
         out_value_ff  <= s1_use_ram_ff ? rd_data : '0;
         out_status_ff <= s1_status_ff;
         out_count_ff  <= s1_count_ff;
      end
   end

   deq_ram #(
      .WIDTH (DEQ_DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign occ_ext        = {{DEQ_OCC_W{1'b0}}, out_count_ff};
   assign rsp_valid      = out_v_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_occupancy  = occ_ext[DEQ_OCC_W-1:0];
   assign rsp_is_empty   = (out_count_ff == '0);

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Deque checker
// Port-level assertions on the response channel of the deque core.
// ----------------------------------------------------------------------------
module deq_checker
   import deq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DEQ_DATA_W-1:0] rsp_read_value,
   input logic [1:0]            rsp_status,
   input logic [DEQ_OCC_W-1:0]  rsp_occupancy,
   input logic                  rsp_is_empty
);

   // An empty response carries no word and an empty queue.
   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_read_value == '0)
      else $error("empty status with data or non-empty flag");

   // A dropped push leaves a non-empty queue and no word.
   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> !rsp_is_empty && rsp_read_value == '0)
      else $error("full status with data or empty flag");

   // Hold a stalled response.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // No response straight out of reset, nor from an idle input with nothing in flight.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid && !$past(req_valid) && !$past(rsp_valid)
      && !$past(reset) && !$past(reset, 2) && !$past(req_valid, 2) |=> !rsp_valid)
      else $error("response without request");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and read requests at both ends and checks each response
// against a behavioural deque or, for typed table rows, the row's own want.
// A short directed table covers the empty queue, unused command codes, word
// extremes and head wrap. Random traffic follows: a mix, a fill past full, a
// short mix, a drain past empty and a closing mix. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench
   import deq_pkg::*;
();

   localparam int PTR_W       = $clog2(DEQ_DEPTH);
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 100;

   // Command codes the queue ignores
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [DEQ_DATA_W-1:0] read_value;
      status_type            status;
      logic [DEQ_OCC_W-1:0]  occupancy;
      logic                  is_empty;
   } deque_result_type;

   typedef struct {
      logic [2:0]            cmd;
      logic [DEQ_DATA_W-1:0] value;
      bit                    typed;
      deque_result_type      want;
   } step_row_type;

   localparam deque_result_type EMPTY_RSP = '{32'd0, ST_EMPTY, 11'd0, 1'b1};
   localparam deque_result_type NONE_RSP  = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_command = 3'd0;
   logic [DEQ_DATA_W-1:0] req_push_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DEQ_DATA_W-1:0] rsp_read_value;
   logic [1:0]            rsp_status;
   logic [DEQ_OCC_W-1:0]  rsp_occupancy;
   logic                  rsp_is_empty;

   // Behavioural copy of the queue
   logic [DEQ_DATA_W-1:0] model_mem [DEQ_DEPTH];
   logic [PTR_W-1:0]      model_head  = '0;
   logic [DEQ_OCC_W-1:0]  model_count = '0;

   deque_result_type pending_results [$];
   int               failures     = 0;
   int               cycle_count  = 0;
   bit               steady       = 1'b0;
   bit               hold_pending = 1'b0;
   int               hold_left    = 0;

   step_row_type directed_steps [23] = '{
      '{CMD_POP_FRONT,  32'hdeadbeef, 1'b1, EMPTY_RSP},
      '{CMD_POP_BACK,   32'h12345678, 1'b1, EMPTY_RSP},
      '{CMD_READ_FRONT, 32'h00000000, 1'b1, EMPTY_RSP},
      '{CMD_READ_BACK,  32'hffffffff, 1'b1, EMPTY_RSP},
      '{CMD_SPARE_6,    32'hffffffff, 1'b1, '{32'd0, ST_OK, 11'd0, 1'b1}},
      '{CMD_SPARE_7,    32'h80000000, 1'b1, '{32'd0, ST_OK, 11'd0, 1'b1}},
      '{CMD_PUSH_FRONT, 32'h80000000, 1'b1, '{32'd0, ST_OK, 11'd1, 1'b0}},
      '{CMD_PUSH_BACK,  32'h7fffffff, 1'b1, '{32'd0, ST_OK, 11'd2, 1'b0}},
      '{CMD_READ_FRONT, 32'h00000000, 1'b1, '{32'h80000000, ST_OK, 11'd2, 1'b0}},
      '{CMD_READ_BACK,  32'hffffffff, 1'b1, '{32'h7fffffff, ST_OK, 11'd2, 1'b0}},
      '{CMD_PUSH_FRONT, 32'hffffffff, 1'b1, '{32'd0, ST_OK, 11'd3, 1'b0}},
      '{CMD_PUSH_BACK,  32'h00000000, 1'b1, '{32'd0, ST_OK, 11'd4, 1'b0}},
      '{CMD_SPARE_6,    32'h5a5a5a5a, 1'b1, '{32'd0, ST_OK, 11'd4, 1'b0}},
      '{CMD_POP_BACK,   32'hffffffff, 1'b1, '{32'd0, ST_OK, 11'd3, 1'b0}},
      '{CMD_POP_FRONT,  32'h00000000, 1'b1, '{32'hffffffff, ST_OK, 11'd2, 1'b0}},
      '{CMD_PUSH_BACK,  32'h55555555, 1'b0, NONE_RSP},
      '{CMD_PUSH_FRONT, 32'haaaaaaaa, 1'b0, NONE_RSP},
      '{CMD_POP_FRONT,  32'h0000ffff, 1'b0, NONE_RSP},
      '{CMD_POP_BACK,   32'hffff0000, 1'b0, NONE_RSP},
      '{CMD_POP_BACK,   32'h00000001, 1'b0, NONE_RSP},
      '{CMD_POP_FRONT,  32'h80000001, 1'b0, NONE_RSP},
      '{CMD_POP_FRONT,  32'h7ffffffe, 1'b1, EMPTY_RSP},
      '{CMD_READ_BACK,  32'hfffffffe, 1'b1, EMPTY_RSP}
   };

   double_ended_queue_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] base,
                                                   input int offset);
      return PTR_W'((int'(base) + offset) % DEQ_DEPTH);
   endfunction

   // Apply one command to the behavioural queue and return its response
   function automatic deque_result_type deque_apply(input logic [2:0] cmd,
                                                    input logic [DEQ_DATA_W-1:0] val);
      deque_result_type res;
      logic [PTR_W-1:0] slot;
      res = '{read_value: '0, status: ST_OK, occupancy: '0, is_empty: 1'b0};
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (model_count == DEQ_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  model_head = (model_head == 0) ? PTR_W'(DEQ_DEPTH - 1) : model_head - 1'b1;
                  slot = model_head;
               end else begin
                  slot = slot_after(model_head, int'(model_count));
               end
               model_mem[slot] = val;
               model_count++;
            end
         end
         CMD_POP_FRONT, CMD_READ_FRONT: begin
            if (model_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.read_value = model_mem[model_head];
               if (cmd == CMD_POP_FRONT) begin
                  model_head = slot_after(model_head, 1);
                  model_count--;
               end
            end
         end
         CMD_POP_BACK, CMD_READ_BACK: begin
            if (model_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.read_value = model_mem[slot_after(model_head, int'(model_count) - 1)];
               if (cmd == CMD_POP_BACK) model_count--;
            end
         end
         default: ;
      endcase
      res.occupancy = model_count;
      res.is_empty  = (model_count == 0);
      return res;
   endfunction

   function automatic logic [DEQ_DATA_W-1:0] random_word();
      case ($urandom_range(19))
         0:       return 32'h80000000;
         1:       return 32'h7fffffff;
         2:       return 32'hffffffff;
         3:       return 32'h00000000;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request, hold it until taken, then log its expected response
   task automatic issue_request(input logic [2:0] cmd, input logic [DEQ_DATA_W-1:0] val,
                                input bit typed, input deque_result_type want);
      deque_result_type predicted;
      if (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_push_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = deque_apply(cmd, val);
      if (typed) predicted = want;
      pending_results.insert(pending_results.size(), predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic run_mix(input int n_items);
      int         done;
      int         pick;
      logic [2:0] cmd;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(99);
         if (pick < 45)      cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else if (pick < 75) cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         else if (pick < 95) cmd = $urandom_range(1) ? CMD_READ_BACK : CMD_READ_FRONT;
         else                cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
         issue_request(cmd, random_word(), 1'b0, NONE_RSP);
         if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) done++;
      end
   endtask

   // Push until full, then a few more so that dropped pushes are flagged
   task automatic fill_past_full();
      int         extra;
      logic [2:0] cmd;
      extra = 0;
      while (extra < 8) begin
         if ($urandom_range(9) == 0)
            cmd = $urandom_range(1) ? CMD_READ_BACK : CMD_READ_FRONT;
         else
            cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         if (model_count == DEQ_DEPTH) extra++;
         issue_request(cmd, random_word(), 1'b0, NONE_RSP);
      end
   endtask

   task automatic drain_past_empty();
      int         extra;
      logic [2:0] cmd;
      extra = 0;
      while (extra < 6) begin
         if ($urandom_range(9) == 0)
            cmd = $urandom_range(1) ? CMD_READ_BACK : CMD_READ_FRONT;
         else
            cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         if (model_count == 0) extra++;
         issue_request(cmd, random_word(), 1'b0, NONE_RSP);
      end
   endtask

   // Response side: check, then choose the stall for the next cycle
   always @(posedge clock) begin
      deque_result_type got;
      deque_result_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_read_value, status_type'(rsp_status), rsp_occupancy, rsp_is_empty};
         if (pending_results.size() == 0) begin
            $error("unexpected response: read_value %h status %0d", rsp_read_value,
                   rsp_status);
            failures++;
         end else begin
            exp_rsp = pending_results[0];
            pending_results.delete(0);
            if (got.read_value !== exp_rsp.read_value) begin
               $error("read_value: expected %h, got %h", exp_rsp.read_value, got.read_value);
               failures++;
            end
            if (got.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
               failures++;
            end
            if (got.occupancy !== exp_rsp.occupancy) begin
               $error("occupancy: expected %0d, got %0d", exp_rsp.occupancy, got.occupancy);
               failures++;
            end
            if (got.is_empty !== exp_rsp.is_empty) begin
               $error("is_empty: expected %0d, got %0d", exp_rsp.is_empty, got.is_empty);
               failures++;
            end
         end
      end
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 13);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i])
         issue_request(directed_steps[i].cmd, directed_steps[i].value,
                       directed_steps[i].typed, directed_steps[i].want);

      run_mix(100);

      // Fill without idling; the response side holds off for a while early on
      steady       = 1'b1;
      hold_pending = 1'b1;
      fill_past_full();
      steady = 1'b0;
      wait_drained();
      run_mix(20);
      drain_past_empty();
      wait_drained();
      run_mix(100);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_core.sv
rtl/deq_checker.sv
dv/testbench.sv
